>>> hw/rtl/glp_pkg.sv
`default_nettype none

package glp_pkg;

  localparam int NUM_VERTICES = 64;

  localparam int ROW_W = 64;
  localparam int VTX_W = 6;
  localparam int OUT_CNT_W = 7;

  localparam int IDX_W = $clog2(NUM_VERTICES);
  localparam int SUM_W = $clog2(NUM_VERTICES + 1);
  localparam int DEG_W = $clog2(ROW_W + 1);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_PRUNE  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic             clear;
    logic             insert;
    logic             shift;
    logic             apply;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    row_t             leaf_mask;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/graph_leaf_pruning_top.sv
// Clear and insert items give no result.
// A query rotates all rows once through the cell chain; its result is loaded
// into the output register once that register no longer holds a stalled result.
// A prune alternates scan and apply rounds until a scan finds no leaf.
// New items are taken only while no query or prune is at work.
// Reset is asynchronous and active low and clears the whole adjacency matrix.
`default_nettype none

module graph_leaf_pruning_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic [glp_pkg::VTX_W-1:0]       vertex_a_i,
  input  logic [glp_pkg::VTX_W-1:0]       vertex_b_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [glp_pkg::OUT_CNT_W-1:0]   vertex_degree_o,
  output logic [glp_pkg::ROW_W-1:0]       neighbor_mask_o,
  output logic [glp_pkg::OUT_CNT_W-1:0]   removed_count_o
);

  glp_pkg::cell_cmd_t cmd;
  glp_pkg::row_t      rows [glp_pkg::NUM_VERTICES];

  glp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .head_row_i      (rows[0]),
    .cmd_o           (cmd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_degree_o (vertex_degree_o),
    .neighbor_mask_o (neighbor_mask_o),
    .removed_count_o (removed_count_o)
  );

  for (genvar i = 0; i < glp_pkg::NUM_VERTICES; i++) begin : g_cell
    localparam int Nxt = (i + 1) % glp_pkg::NUM_VERTICES;
    glp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cell_idx_i (glp_pkg::VTX_W'(i)),
      .leaf_i     (cmd.leaf_mask[i]),
      .next_row_i (rows[Nxt]),
      .row_o      (rows[i])
    );
  end

endmodule

`default_nettype wire

>>> hw/rtl/glp_cell.sv
`default_nettype none

module glp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  glp_pkg::cell_cmd_t          cmd_i,
  input  logic [glp_pkg::VTX_W-1:0]   cell_idx_i,
  input  logic                        leaf_i,
  input  glp_pkg::row_t               next_row_i,
  output glp_pkg::row_t               row_o
);

  glp_pkg::row_t row_q;
  glp_pkg::row_t row_d;

  always_comb begin
    row_d = row_q;
    priority if (cmd_i.clear) begin
      row_d = '0;
    end else if (cmd_i.insert) begin
      if (cell_idx_i == cmd_i.vertex_a) begin
        row_d[cmd_i.vertex_b] = 1'b1;
      end
      if (cell_idx_i == cmd_i.vertex_b) begin
        row_d[cmd_i.vertex_a] = 1'b1;
      end
    end else if (cmd_i.shift) begin
      row_d = next_row_i;
    end else if (cmd_i.apply) begin
      row_d = leaf_i ? '0 : (row_q & ~cmd_i.leaf_mask);
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

>>> hw/rtl/glp_ctrl.sv
`default_nettype none

module glp_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic [glp_pkg::VTX_W-1:0]       vertex_a_i,
  input  logic [glp_pkg::VTX_W-1:0]       vertex_b_i,
  input  glp_pkg::row_t                   head_row_i,
  output glp_pkg::cell_cmd_t              cmd_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [glp_pkg::OUT_CNT_W-1:0]   vertex_degree_o,
  output glp_pkg::row_t                   neighbor_mask_o,
  output logic [glp_pkg::OUT_CNT_W-1:0]   removed_count_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_APPLY  = 5'b00100,
    ST_QUERY  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  localparam logic [glp_pkg::VTX_W:0] NumExt = (glp_pkg::VTX_W + 1)'(glp_pkg::NUM_VERTICES);
  localparam logic [glp_pkg::IDX_W-1:0] LastIdx = glp_pkg::IDX_W'(glp_pkg::NUM_VERTICES - 1);

  function automatic logic [glp_pkg::DEG_W-1:0] popcount(input glp_pkg::row_t row);
    logic [glp_pkg::DEG_W-1:0] n;
    n = '0;
    for (int j = 0; j < glp_pkg::ROW_W; j++) begin
      n = n + glp_pkg::DEG_W'(row[j]);
    end
    return n;
  endfunction

  state_e                         state_q, state_d;
  logic [glp_pkg::IDX_W-1:0]      cnt_q, cnt_d;
  glp_pkg::row_t                  leaves_q, leaves_d;
  logic                           hit_q, hit_d;
  logic [glp_pkg::SUM_W-1:0]      removed_q, removed_d;
  logic [glp_pkg::VTX_W-1:0]      qa_q, qa_d;
  glp_pkg::row_t                  qrow_q, qrow_d;
  logic [glp_pkg::DEG_W-1:0]      qdeg_q, qdeg_d;
  logic                           prune_q, prune_d;
  logic                           out_valid_q, out_valid_d;
  logic [glp_pkg::OUT_CNT_W-1:0]  deg_q, rem_q;
  glp_pkg::row_t                  mask_q;

  logic          head_leaf;
  logic          last;
  logic          out_load;
  logic          in_range;
  glp_pkg::req_e req;

  assign req        = glp_pkg::req_e'(req_type_i);
  assign head_leaf  = (head_row_i != '0) &&
                      ((head_row_i & (head_row_i - glp_pkg::row_t'(1))) == '0);
  assign last       = (cnt_q == LastIdx);
  assign in_range   = ({1'b0, vertex_a_i} < NumExt) && ({1'b0, vertex_b_i} < NumExt);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    leaves_d  = leaves_q;
    hit_d     = hit_q;
    removed_d = removed_q;
    qa_d      = qa_q;
    qrow_d    = qrow_q;
    qdeg_d    = qdeg_q;
    prune_d   = prune_q;
    out_load  = 1'b0;
    cmd_o           = '0;
    cmd_o.vertex_a  = vertex_a_i;
    cmd_o.vertex_b  = vertex_b_i;
    cmd_o.leaf_mask = leaves_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req)
            glp_pkg::REQ_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            glp_pkg::REQ_INSERT: begin
              cmd_o.insert = in_range;
            end
            glp_pkg::REQ_PRUNE: begin
              state_d   = ST_SCAN;
              cnt_d     = '0;
              leaves_d  = '0;
              hit_d     = 1'b0;
              removed_d = '0;
              prune_d   = 1'b1;
            end
            glp_pkg::REQ_QUERY: begin
              state_d = ST_QUERY;
              cnt_d   = '0;
              qa_d    = vertex_a_i;
              qrow_d  = '0;
              qdeg_d  = '0;
              prune_d = 1'b0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.shift = 1'b1;
        leaves_d[glp_pkg::NUM_VERTICES-1:0] =
          {head_leaf, leaves_q[glp_pkg::NUM_VERTICES-1:1]};
        if (head_leaf) begin
          hit_d     = 1'b1;
          removed_d = removed_q + glp_pkg::SUM_W'(1);
        end
        cnt_d = cnt_q + glp_pkg::IDX_W'(1);
        if (last) begin
          cnt_d   = '0;
          state_d = (hit_q || head_leaf) ? ST_APPLY : ST_RESULT;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        leaves_d    = '0;
        hit_d       = 1'b0;
        cnt_d       = '0;
        state_d     = ST_SCAN;
      end
      ST_QUERY: begin
        cmd_o.shift = 1'b1;
        if (glp_pkg::VTX_W'(cnt_q) == qa_q) begin
          qrow_d = head_row_i;
          qdeg_d = popcount(head_row_i);
        end
        cnt_d = cnt_q + glp_pkg::IDX_W'(1);
        if (last) begin
          cnt_d   = '0;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      leaves_q    <= '0;
      hit_q       <= 1'b0;
      removed_q   <= '0;
      prune_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      leaves_q    <= leaves_d;
      hit_q       <= hit_d;
      removed_q   <= removed_d;
      prune_q     <= prune_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q   <= qa_d;
    qrow_q <= qrow_d;
    qdeg_q <= qdeg_d;
    if (out_load) begin
      deg_q  <= prune_q ? '0 : glp_pkg::OUT_CNT_W'(qdeg_q);
      mask_q <= prune_q ? '0 : qrow_q;
      rem_q  <= prune_q ? glp_pkg::OUT_CNT_W'(removed_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_degree_o = deg_q;
  assign neighbor_mask_o = mask_q;
  assign removed_count_o = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/glp_checker.sv
`default_nettype none

module glp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [1:0]                      req_type_i,
  input logic [glp_pkg::VTX_W-1:0]       vertex_a_i,
  input logic [glp_pkg::VTX_W-1:0]       vertex_b_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [glp_pkg::OUT_CNT_W-1:0]   vertex_degree_o,
  input logic [glp_pkg::ROW_W-1:0]       neighbor_mask_o,
  input logic [glp_pkg::OUT_CNT_W-1:0]   removed_count_o
);

  localparam logic [glp_pkg::OUT_CNT_W-1:0] MaxCnt =
    glp_pkg::OUT_CNT_W'(glp_pkg::NUM_VERTICES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(neighbor_mask_o))
    else $error("Stalled result item changed.");

  a_long_item_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (req_type_i == glp_pkg::REQ_PRUNE || req_type_i == glp_pkg::REQ_QUERY)
    |=> in_stall_o)
    else $error("Input not stalled after a prune or query item.");

  a_prune_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != '0 |->
    vertex_degree_o == '0 && neighbor_mask_o == '0)
    else $error("Prune result carries query data.");

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_degree_o != '0 |->
    neighbor_mask_o != '0 && removed_count_o == '0)
    else $error("Query result is inconsistent.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vertex_degree_o <= MaxCnt && removed_count_o <= MaxCnt)
    else $error("Result count out of range.");

endmodule

bind graph_leaf_pruning_top glp_checker u_glp_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 195;

  typedef struct packed {
    logic [glp_pkg::OUT_CNT_W-1:0] degree;
    glp_pkg::row_t                 mask;
    logic [glp_pkg::OUT_CNT_W-1:0] removed;
  } result_t;

  typedef struct packed {
    glp_pkg::req_e             req;
    logic [glp_pkg::VTX_W-1:0] a;
    logic [glp_pkg::VTX_W-1:0] b;
    logic                      fixed;
    result_t                   res;
  } item_t;

  localparam result_t NO_RES = '0;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    req_type = glp_pkg::REQ_CLEAR;
  logic [glp_pkg::VTX_W-1:0]     vertex_a = '0;
  logic [glp_pkg::VTX_W-1:0]     vertex_b = '0;
  logic                          out_valid_o;
  logic                          out_stall = 1'b0;
  logic [glp_pkg::OUT_CNT_W-1:0] vertex_degree_o;
  glp_pkg::row_t                 neighbor_mask_o;
  logic [glp_pkg::OUT_CNT_W-1:0] removed_count_o;

  graph_leaf_pruning_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type),
    .vertex_a_i      (vertex_a),
    .vertex_b_i      (vertex_b),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .vertex_degree_o (vertex_degree_o),
    .neighbor_mask_o (neighbor_mask_o),
    .removed_count_o (removed_count_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  glp_pkg::row_t adj_rows [glp_pkg::NUM_VERTICES];
  result_t       pending_results [$];
  item_t         scenario_q [$];
  result_t       want;
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_req = 0;
  int            hold_ack = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;

  item_t directed_tab [25] = '{
    '{glp_pkg::REQ_QUERY,  6'd0,  6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}},
    '{glp_pkg::REQ_QUERY,  6'd63, 6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}},
    '{glp_pkg::REQ_PRUNE,  6'd0,  6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}},
    '{glp_pkg::REQ_INSERT, 6'd0,  6'd63, 1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd0,  6'd0,  1'b1, '{7'd1, 64'h8000_0000_0000_0000, 7'd0}},
    '{glp_pkg::REQ_QUERY,  6'd63, 6'd63, 1'b1, '{7'd1, 64'h1, 7'd0}},
    '{glp_pkg::REQ_INSERT, 6'd0,  6'd63, 1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd0,  6'd0,  1'b1, '{7'd1, 64'h8000_0000_0000_0000, 7'd0}},
    '{glp_pkg::REQ_INSERT, 6'd5,  6'd5,  1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd5,  6'd0,  1'b1, '{7'd1, 64'h20, 7'd0}},
    '{glp_pkg::REQ_PRUNE,  6'd63, 6'd63, 1'b1, '{7'd0, 64'd0, 7'd3}},
    '{glp_pkg::REQ_QUERY,  6'd0,  6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}},
    '{glp_pkg::REQ_INSERT, 6'd1,  6'd2,  1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd2,  6'd3,  1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd10, 6'd11, 1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd11, 6'd12, 1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd12, 6'd10, 1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd12, 6'd13, 1'b0, NO_RES},
    '{glp_pkg::REQ_INSERT, 6'd42, 6'd21, 1'b0, NO_RES},
    '{glp_pkg::REQ_PRUNE,  6'd0,  6'd0,  1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd12, 6'd0,  1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd2,  6'd0,  1'b0, NO_RES},
    '{glp_pkg::REQ_CLEAR,  6'd63, 6'd63, 1'b0, NO_RES},
    '{glp_pkg::REQ_QUERY,  6'd12, 6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}},
    '{glp_pkg::REQ_PRUNE,  6'd0,  6'd0,  1'b1, '{7'd0, 64'd0, 7'd0}}
  };

  function automatic bit graph_apply(input item_t it, output result_t res);
    glp_pkg::row_t leaves;
    int            removed;
    res = '0;
    removed = 0;
    case (it.req)
      glp_pkg::REQ_CLEAR: begin
        for (int i = 0; i < glp_pkg::NUM_VERTICES; i++) adj_rows[i] = '0;
        return 1'b0;
      end
      glp_pkg::REQ_INSERT: begin
        adj_rows[it.a][it.b] = 1'b1;
        adj_rows[it.b][it.a] = 1'b1;
        return 1'b0;
      end
      glp_pkg::REQ_PRUNE: begin
        do begin
          leaves = '0;
          for (int i = 0; i < glp_pkg::NUM_VERTICES; i++) begin
            if ($countones(adj_rows[i]) == 1) leaves[i] = 1'b1;
          end
          for (int i = 0; i < glp_pkg::NUM_VERTICES; i++) begin
            if (leaves[i]) begin
              adj_rows[i] = '0;
              removed++;
            end else begin
              adj_rows[i] &= ~leaves;
            end
          end
        end while (leaves != '0);
        res.removed = glp_pkg::OUT_CNT_W'(removed);
        return 1'b1;
      end
      default: begin
        res.mask = adj_rows[it.a];
        res.degree = glp_pkg::OUT_CNT_W'($countones(adj_rows[it.a]));
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void add_item(glp_pkg::req_e r, int a, int b);
    item_t it;
    it = '0;
    it.req = r;
    it.a = glp_pkg::VTX_W'(a);
    it.b = glp_pkg::VTX_W'(b);
    scenario_q = {scenario_q, it};
  endfunction

  function automatic void add_edge(int x, int y);
    if ($urandom_range(1)) add_item(glp_pkg::REQ_INSERT, x, y);
    else add_item(glp_pkg::REQ_INSERT, y, x);
  endfunction

  task automatic send_item(input item_t it);
    result_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= it.req;
    vertex_a <= it.a;
    vertex_b <= it.b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (graph_apply(it, pred)) pending_results = {pending_results, (it.fixed ? it.res : pred)};
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: degree %0d mask %h removed %0d",
                 $time, vertex_degree_o, neighbor_mask_o, removed_count_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (vertex_degree_o !== want.degree) begin
          $display("%0t: vertex_degree expected %0d actual %0d",
                   $time, want.degree, vertex_degree_o);
          errors++;
        end
        if (neighbor_mask_o !== want.mask) begin
          $display("%0t: neighbor_mask expected %h actual %h",
                   $time, want.mask, neighbor_mask_o);
          errors++;
        end
        if (removed_count_o !== want.removed) begin
          $display("%0t: removed_count expected %0d actual %0d",
                   $time, want.removed, removed_count_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    int base;
    int hub;
    int j;
    int tmp;
    int sent;
    int perm [glp_pkg::NUM_VERTICES];
    for (int i = 0; i < glp_pkg::NUM_VERTICES; i++) adj_rows[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
      if (phase == 0) begin
        foreach (directed_tab[i]) send_item(directed_tab[i]);
      end
      if (phase == 2) hold_req++;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        kind = $urandom_range(99);
        if (sent == 0) kind = (phase == 1) ? 67 : 60;
        if (kind < 55) begin
          if ($urandom_range(3) != 0) add_item(glp_pkg::REQ_CLEAR, $urandom, $urandom);
          n = $urandom_range(2, 16);
          base = $urandom_range(0, glp_pkg::NUM_VERTICES - n);
          if ($urandom_range(1)) begin
            for (int v = 1; v < n; v++) add_edge(base + v, base + $urandom_range(0, v - 1));
          end
          repeat ($urandom_range(0, n)) begin
            add_edge(base + $urandom_range(0, n - 1), base + $urandom_range(0, n - 1));
          end
          repeat ($urandom_range(0, 2)) add_item(glp_pkg::REQ_QUERY,
                                                 base + $urandom_range(0, n - 1), $urandom);
          add_item(glp_pkg::REQ_PRUNE, $urandom, $urandom);
          repeat ($urandom_range(1, 3)) add_item(glp_pkg::REQ_QUERY,
                                                 base + $urandom_range(0, n - 1), $urandom);
        end else if (kind < 65) begin
          add_item(glp_pkg::REQ_CLEAR, $urandom, $urandom);
          for (int i = 0; i < glp_pkg::NUM_VERTICES; i++) perm[i] = i;
          for (int i = glp_pkg::NUM_VERTICES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          n = (sent == 0 || $urandom_range(7) == 0) ? glp_pkg::NUM_VERTICES :
              $urandom_range(3, 20);
          for (int v = 1; v < n; v++) add_edge(perm[v - 1], perm[v]);
          if ($urandom_range(1)) add_edge(perm[n - 1], perm[$urandom_range(0, n - 3)]);
          add_item(glp_pkg::REQ_QUERY, perm[n - 1], $urandom);
          add_item(glp_pkg::REQ_PRUNE, $urandom, $urandom);
          add_item(glp_pkg::REQ_QUERY, perm[0], $urandom);
          add_item(glp_pkg::REQ_QUERY, perm[n - 1], $urandom);
        end else if (kind < 70) begin
          add_item(glp_pkg::REQ_CLEAR, $urandom, $urandom);
          hub = $urandom_range(0, glp_pkg::NUM_VERTICES - 1);
          for (int v = 0; v < glp_pkg::NUM_VERTICES; v++) add_edge(hub, v);
          add_item(glp_pkg::REQ_QUERY, hub, $urandom);
          add_item(glp_pkg::REQ_PRUNE, $urandom, $urandom);
          add_item(glp_pkg::REQ_QUERY, hub, $urandom);
        end else begin
          repeat ($urandom_range(1, 8)) add_item(glp_pkg::req_e'($urandom_range(3)),
                                                 $urandom, $urandom);
        end
        while (scenario_q.size() > 0) begin
          send_item(scenario_q.pop_front());
          sent++;
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
